FILE: src/first_best_fit_heap_allocator_assert.svh
// assertion macros for the heap allocator
`ifndef FIRST_BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FBFHA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FBFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FBFHA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define FBFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/fbfha_pkg.sv
// shared constants, types and codes of the heap allocator
package fbfha_pkg;
   localparam int MAX_SEGMENTS = 64;
   localparam int HEAP_BYTES   = 1048576;
   localparam int FIELD_W      = 21;
   localparam int HDR_W        = 13;
   localparam int SZ_W         = 32;
   localparam int IDX_W        = $clog2(MAX_SEGMENTS);
   localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
   localparam int OFF_W        = IDX_W + SZ_W + 2;
   localparam int ENT_W        = SZ_W + 1;
   localparam int CSR_IDX_W    = 2;

   localparam logic [OFF_W-1:0]   HEAP_LIMIT_MAX = OFF_W'(HEAP_BYTES);
   localparam logic               FIT_RESET      = 1'b0;
   localparam logic [HDR_W-1:0]   HDR_RESET      = HDR_W'(32);
   localparam logic [FIELD_W-1:0] LIMIT_RESET    = FIELD_W'(1048576);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIT_MODE     = 2'd0,
      CSR_HEADER_BYTES = 2'd1,
      CSR_HEAP_LIMIT   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_NOP  = 2'd1,
      STATUS_OOM  = 2'd2
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      WALK_SCAN  = 2'd0,
      WALK_SHIFT = 2'd1,
      WALK_STATS = 2'd2
   } walk_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic decide;
      logic patch_a;
      logic patch_b;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } sts_type;
endpackage

FILE: src/fbfha_ram.sv
// generic single write port memory with registered read
module fbfha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/fbfha_ctrl.sv
// sequencing state machine of the heap allocator
module fbfha_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  fbfha_pkg::sts_type sts,
   output fbfha_pkg::cmd_type cmd,
   output logic              busy
);
   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_SCAN    = 8'b0000_0010,
      ST_DECIDE  = 8'b0000_0100,
      ST_SHIFT   = 8'b0000_1000,
      ST_PATCH_A = 8'b0001_0000,
      ST_PATCH_B = 8'b0010_0000,
      ST_STATS   = 8'b0100_0000,
      ST_RESP    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.walk_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (sts.walk_done) begin
               state_in = ST_PATCH_A;
            end
         end
         ST_PATCH_A: begin
            cmd.patch_a = 1'b1;
            state_in    = ST_PATCH_B;
         end
         ST_PATCH_B: begin
            cmd.patch_b = 1'b1;
            state_in    = ST_STATS;
         end
         ST_STATS: begin
            if (sts.walk_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

FILE: src/fbfha_dp.sv
// segment table, walk engine, search, update and statistics datapath
module fbfha_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  fbfha_pkg::cmd_type                cmd,
   output fbfha_pkg::sts_type                sts,
   input  logic                              req_type,
   input  logic [fbfha_pkg::FIELD_W-1:0]     req_size,
   input  logic [fbfha_pkg::FIELD_W-1:0]     req_free_addr,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbfha_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fbfha_pkg::FIELD_W-1:0]     csr_wdata,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [fbfha_pkg::FIELD_W-1:0]     rsp_payload_addr,
   output logic [fbfha_pkg::FIELD_W-1:0]     rsp_largest_free,
   output logic [fbfha_pkg::FIELD_W-1:0]     rsp_total_free
);
   localparam int FW = fbfha_pkg::FIELD_W;
   localparam int SW = fbfha_pkg::SZ_W;
   localparam int IW = fbfha_pkg::IDX_W;
   localparam int CW = fbfha_pkg::CNT_W;
   localparam int OW = fbfha_pkg::OFF_W;
   localparam int EW = fbfha_pkg::ENT_W;

   // configuration registers
   logic                       fit_mode_ff;
   logic [fbfha_pkg::HDR_W-1:0] hdr_ff;
   logic [FW-1:0]              limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= fbfha_pkg::FIT_RESET;
         hdr_ff      <= fbfha_pkg::HDR_RESET;
         limit_ff    <= fbfha_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            fbfha_pkg::CSR_FIT_MODE:     fit_mode_ff <= csr_wdata[0];
            fbfha_pkg::CSR_HEADER_BYTES: hdr_ff <= csr_wdata[fbfha_pkg::HDR_W-1:0];
            fbfha_pkg::CSR_HEAP_LIMIT:   limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request word
   logic          req_type_ff;
   logic [FW-1:0] req_size_ff;
   logic [FW-1:0] free_addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff  <= req_type;
         req_size_ff  <= req_size;
         free_addr_ff <= req_free_addr;
      end
   end

   logic [SW-1:0] req_sz;
   logic [SW-1:0] hdr_sz;
   assign req_sz = SW'(req_size_ff);
   assign hdr_sz = SW'(hdr_ff);

   // segment count
   logic [CW-1:0] count_ff, cnt_in;

   // walk engine
   logic [IW-1:0]           walk_ptr_ff, rd_idx_ff;
   logic [CW-1:0]           walk_left_ff;
   logic                    walk_up_ff, rd_vld_ff;
   fbfha_pkg::walk_type     walk_kind_ff;
   logic                    issue;
   logic                    start_walk, start_up;
   logic [IW-1:0]           start_ptr;
   logic [CW-1:0]           start_n;
   fbfha_pkg::walk_type     start_kind;

   logic [IW-1:0] sh_start_in, sh_delta_in, sh_delta_ff;
   logic [CW-1:0] sh_n_in;

   assign issue = (walk_left_ff != '0);
   assign sts.walk_done = !issue && !rd_vld_ff;

   always_comb begin
      start_walk = 1'b0;
      start_ptr  = '0;
      start_n    = count_ff;
      start_up   = 1'b1;
      start_kind = fbfha_pkg::WALK_SCAN;
      if (cmd.scan_start) begin
         start_walk = 1'b1;
      end else if (cmd.decide) begin
         start_walk = 1'b1;
         start_ptr  = sh_start_in;
         start_n    = sh_n_in;
         start_up   = (sh_delta_in != IW'(1));
         start_kind = fbfha_pkg::WALK_SHIFT;
      end else if (cmd.patch_b) begin
         start_walk = 1'b1;
         start_kind = fbfha_pkg::WALK_STATS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_left_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else if (start_walk) begin
         walk_left_ff <= start_n;
         rd_vld_ff    <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         if (issue) begin
            walk_left_ff <= walk_left_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= walk_ptr_ff;
      if (start_walk) begin
         walk_ptr_ff  <= start_ptr;
         walk_up_ff   <= start_up;
         walk_kind_ff <= start_kind;
      end else if (issue) begin
         walk_ptr_ff <= walk_up_ff ? walk_ptr_ff + IW'(1) : walk_ptr_ff - IW'(1);
      end
   end

   // segment table
   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata, ram_rdata;
   logic [SW-1:0] rd_size;
   logic          rd_free;

   fbfha_ram #(
      .WIDTH (EW),
      .DEPTH (fbfha_pkg::MAX_SEGMENTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (walk_ptr_ff),
      .rdata (ram_rdata)
   );

   assign rd_size = ram_rdata[SW-1:0];
   assign rd_free = ram_rdata[SW];

   // search pass
   logic [OW-1:0] off_ff;
   logic          found_ff, lock_ff, matched_ff, grab_ff, has_next_ff, has_prev_ff;
   logic [IW-1:0] pos_ff, idx_ff;
   logic [OW-1:0] pos_off_ff;
   logic [SW-1:0] pos_size_ff, best_ff, idx_size_ff, prev_size_ff, next_size_ff, last_size_ff;
   logic          idx_free_ff, prev_free_ff, next_free_ff, last_free_ff;
   logic          scan_proc, cand, exact;
   logic [SW-1:0] diff;

   assign scan_proc = rd_vld_ff && (walk_kind_ff == fbfha_pkg::WALK_SCAN);
   assign cand      = rd_free && (rd_size >= req_sz);
   assign exact     = (rd_size == req_sz);
   assign diff      = rd_size - req_sz;

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         off_ff      <= '0;
         found_ff    <= 1'b0;
         lock_ff     <= 1'b0;
         matched_ff  <= 1'b0;
         grab_ff     <= 1'b0;
         has_next_ff <= 1'b0;
      end else if (scan_proc) begin
         off_ff       <= off_ff + OW'(hdr_ff) + OW'(rd_size);
         last_size_ff <= rd_size;
         last_free_ff <= rd_free;
         if (!lock_ff && cand && (!fit_mode_ff || exact)) begin
            found_ff    <= 1'b1;
            lock_ff     <= 1'b1;
            pos_ff      <= rd_idx_ff;
            pos_off_ff  <= off_ff;
            pos_size_ff <= rd_size;
         end else if (!lock_ff && cand && fit_mode_ff && (!found_ff || diff < best_ff)) begin
            found_ff    <= 1'b1;
            pos_ff      <= rd_idx_ff;
            pos_off_ff  <= off_ff;
            pos_size_ff <= rd_size;
            best_ff     <= diff;
         end
         if (grab_ff) begin
            has_next_ff  <= 1'b1;
            next_size_ff <= rd_size;
            next_free_ff <= rd_free;
            grab_ff      <= 1'b0;
         end
         if (!matched_ff && (off_ff + OW'(hdr_ff) == OW'(free_addr_ff))) begin
            matched_ff   <= 1'b1;
            grab_ff      <= 1'b1;
            idx_ff       <= rd_idx_ff;
            idx_size_ff  <= rd_size;
            idx_free_ff  <= rd_free;
            has_prev_ff  <= (rd_idx_ff != '0);
            prev_size_ff <= last_size_ff;
            prev_free_ff <= last_free_ff;
         end
      end
   end

   // update plan
   fbfha_pkg::status_type st_in, st_ff;
   logic [FW-1:0] paddr_in, paddr_ff;
   logic          pa_en_in, pa_en_ff, pb_en_in, pb_en_ff;
   logic [IW-1:0] pa_addr_in, pa_addr_ff, pb_addr_in, pb_addr_ff;
   logic [EW-1:0] pa_data_in, pa_data_ff, pb_data_in, pb_data_ff;
   logic [OW-1:0] limit_eff, grow_need;
   logic          count_full, split, pn, pp;
   logic [CW-1:0] pos_cnt, idx_cnt;

   assign limit_eff  = (OW'(limit_ff) < fbfha_pkg::HEAP_LIMIT_MAX) ?
                       OW'(limit_ff) : fbfha_pkg::HEAP_LIMIT_MAX;
   assign grow_need  = off_ff + OW'(hdr_ff) + OW'(req_size_ff);
   assign count_full = (count_ff == CW'(fbfha_pkg::MAX_SEGMENTS));
   assign split      = ({1'b0, pos_size_ff} >= ({1'b0, req_sz} + {1'b0, hdr_sz}))
                       && !count_full;
   assign pn         = has_next_ff && next_free_ff;
   assign pp         = has_prev_ff && prev_free_ff;
   assign pos_cnt    = CW'(pos_ff);
   assign idx_cnt    = CW'(idx_ff);

   always_comb begin
      st_in       = fbfha_pkg::STATUS_NOP;
      paddr_in    = '0;
      cnt_in      = count_ff;
      sh_n_in     = '0;
      sh_start_in = '0;
      sh_delta_in = '0 - IW'(1);
      pa_en_in    = 1'b0;
      pa_addr_in  = pos_ff;
      pa_data_in  = '0;
      pb_en_in    = 1'b0;
      pb_addr_in  = pos_ff + IW'(1);
      pb_data_in  = {1'b1, pos_size_ff - req_sz - hdr_sz};
      if (req_type_ff == fbfha_pkg::REQ_ALLOC) begin
         if (req_size_ff != '0) begin
            if (found_ff) begin
               st_in      = fbfha_pkg::STATUS_DONE;
               paddr_in   = FW'(pos_off_ff + OW'(hdr_ff));
               pa_en_in   = 1'b1;
               pa_data_in = {1'b0, split ? req_sz : pos_size_ff};
               if (split) begin
                  pb_en_in    = 1'b1;
                  cnt_in      = count_ff + CW'(1);
                  sh_n_in     = count_ff - CW'(1) - pos_cnt;
                  sh_start_in = IW'(count_ff - CW'(1));
                  sh_delta_in = IW'(1);
               end
            end else if (count_full || (grow_need > limit_eff)) begin
               st_in = fbfha_pkg::STATUS_OOM;
            end else begin
               st_in      = fbfha_pkg::STATUS_DONE;
               paddr_in   = FW'(off_ff + OW'(hdr_ff));
               pa_en_in   = 1'b1;
               pa_addr_in = count_ff[IW-1:0];
               pa_data_in = {1'b0, req_sz};
               cnt_in     = count_ff + CW'(1);
            end
         end
      end else if ((free_addr_ff != '0) && matched_ff && !idx_free_ff) begin
         st_in    = fbfha_pkg::STATUS_DONE;
         pa_en_in = 1'b1;
         if (pp && pn) begin
            pa_addr_in  = idx_ff - IW'(1);
            pa_data_in  = {1'b1, prev_size_ff + hdr_sz + idx_size_ff + hdr_sz + next_size_ff};
            sh_start_in = idx_ff + IW'(2);
            sh_n_in     = count_ff - idx_cnt - CW'(2);
            sh_delta_in = '0 - IW'(2);
            cnt_in      = count_ff - CW'(2);
         end else if (pn) begin
            pa_addr_in  = idx_ff;
            pa_data_in  = {1'b1, idx_size_ff + hdr_sz + next_size_ff};
            sh_start_in = idx_ff + IW'(2);
            sh_n_in     = count_ff - idx_cnt - CW'(2);
            cnt_in      = count_ff - CW'(1);
         end else if (pp) begin
            pa_addr_in  = idx_ff - IW'(1);
            pa_data_in  = {1'b1, prev_size_ff + hdr_sz + idx_size_ff};
            sh_start_in = idx_ff + IW'(1);
            sh_n_in     = count_ff - idx_cnt - CW'(1);
            cnt_in      = count_ff - CW'(1);
         end else begin
            pa_addr_in = idx_ff;
            pa_data_in = {1'b1, idx_size_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pa_en_ff <= 1'b0;
         pb_en_ff <= 1'b0;
         st_ff    <= fbfha_pkg::STATUS_NOP;
      end else if (cmd.decide) begin
         count_ff <= cnt_in;
         pa_en_ff <= pa_en_in;
         pb_en_ff <= pb_en_in;
         st_ff    <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         paddr_ff    <= paddr_in;
         sh_delta_ff <= sh_delta_in;
         pa_addr_ff  <= pa_addr_in;
         pa_data_ff  <= pa_data_in;
         pb_addr_ff  <= pb_addr_in;
         pb_data_ff  <= pb_data_in;
      end
   end

   // table writes: shift moves, then the patched entries
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pa_addr_ff;
      ram_wdata = pa_data_ff;
      if (rd_vld_ff && (walk_kind_ff == fbfha_pkg::WALK_SHIFT)) begin
         ram_we    = 1'b1;
         ram_waddr = rd_idx_ff + sh_delta_ff;
         ram_wdata = ram_rdata;
      end else if (cmd.patch_a) begin
         ram_we = pa_en_ff;
      end else if (cmd.patch_b) begin
         ram_we    = pb_en_ff;
         ram_waddr = pb_addr_ff;
         ram_wdata = pb_data_ff;
      end
   end

   // statistics pass
   logic [SW-1:0] largest_ff;
   logic [FW-1:0] total_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.patch_b) begin
         largest_ff <= '0;
         total_ff   <= '0;
      end else if (rd_vld_ff && (walk_kind_ff == fbfha_pkg::WALK_STATS) && rd_free) begin
         if (rd_size > largest_ff) begin
            largest_ff <= rd_size;
         end
         total_ff <= total_ff + FW'(hdr_ff) + rd_size[FW-1:0];
      end
   end

   assign rsp_strobe       = cmd.respond;
   assign rsp_status       = st_ff;
   assign rsp_payload_addr = paddr_ff;
   assign rsp_largest_free = largest_ff[FW-1:0];
   assign rsp_total_free   = total_ff;
endmodule

FILE: src/first_best_fit_heap_allocator.sv
// Heap allocator over an address-ordered table of up to 64 segments, first fit or best
// fit. A request word is taken when start is high and busy is low; its single result
// word appears for exactly one cycle with rsp_strobe and cannot be held off, so the
// receiver must take it then. The table sits in one memory with a registered read that
// is walked once to search, once to shift and once more to gather the free totals. The
// shift walk moves the entries displaced by a split or merge, and the totals walk covers
// the segment count after the request. busy drops in the cycle after the result, so the
// next word can be taken only then. Configuration writes are taken at any time but must
// only be made while busy is low.
`include "first_best_fit_heap_allocator_assert.svh"
module first_best_fit_heap_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_type,
   input  logic [fbfha_pkg::FIELD_W-1:0]   req_size,
   input  logic [fbfha_pkg::FIELD_W-1:0]   req_free_addr,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fbfha_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbfha_pkg::FIELD_W-1:0]   csr_wdata,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_status,
   output logic [fbfha_pkg::FIELD_W-1:0]   rsp_payload_addr,
   output logic [fbfha_pkg::FIELD_W-1:0]   rsp_largest_free,
   output logic [fbfha_pkg::FIELD_W-1:0]   rsp_total_free
);
   fbfha_pkg::cmd_type cmd;
   fbfha_pkg::sts_type sts;

   fbfha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   fbfha_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_size         (req_size),
      .req_free_addr    (req_free_addr),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_payload_addr (rsp_payload_addr),
      .rsp_largest_free (rsp_largest_free),
      .rsp_total_free   (rsp_total_free)
   );

   `FBFHA_ASSERT_IMPL(a_strobe_while_busy, clock, reset, rsp_strobe, busy)
   `FBFHA_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy)
   `FBFHA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   `FBFHA_ASSERT_IMPL(a_no_addr_unless_done, clock, reset, rsp_strobe && (rsp_status != fbfha_pkg::STATUS_DONE), rsp_payload_addr == '0)
endmodule

FILE: bench/testbench.sv
// self-checking bench for the heap allocator: directed table, then random words per configuration
module testbench;
   localparam int FW    = fbfha_pkg::FIELD_W;
   localparam int HW    = fbfha_pkg::HDR_W;
   localparam int NSEG  = fbfha_pkg::MAX_SEGMENTS;
   localparam int HBYTE = fbfha_pkg::HEAP_BYTES;

   typedef struct {
      fbfha_pkg::status_type status;
      logic [FW-1:0]         addr;
      logic [FW-1:0]         largest;
      logic [FW-1:0]         total;
   } alloc_result_type;

   typedef struct {
      fbfha_pkg::req_kind_type kind;
      logic [FW-1:0]           size;
      logic [FW-1:0]           faddr;
      bit                      typed;
      alloc_result_type        res;
   } dir_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic                                req_type;
   logic [FW-1:0]                       req_size;
   logic [FW-1:0]                       req_free_addr;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [fbfha_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [FW-1:0]                       csr_wdata;
   logic                                rsp_strobe;
   logic [1:0]                          rsp_status;
   logic [FW-1:0]                       rsp_payload_addr;
   logic [FW-1:0]                       rsp_largest_free;
   logic [FW-1:0]                       rsp_total_free;

   // shadow heap
   logic [31:0]          shadow_size[NSEG];
   bit                   shadow_free[NSEG];
   int unsigned          shadow_count;
   bit                   cur_fit;
   logic [HW-1:0]        cur_hdr;
   logic [FW-1:0]        cur_limit;

   alloc_result_type     pending_results[$];
   logic [FW-1:0]        live_addrs[$];
   int                   errors;
   dir_row_type          dir_rows[15];

   first_best_fit_heap_allocator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_size(req_size), .req_free_addr(req_free_addr),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_payload_addr(rsp_payload_addr), .rsp_largest_free(rsp_largest_free),
      .rsp_total_free(rsp_total_free)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic longint span_to(int unsigned idx);
      longint off;
      off = 0;
      for (int unsigned i = 0; i < idx && i < shadow_count; i++)
         off += longint'(cur_hdr) + longint'(shadow_size[i]);
      return off;
   endfunction

   function automatic void seg_remove(int unsigned idx);
      for (int unsigned i = idx; i + 1 < shadow_count; i++) begin
         shadow_size[i] = shadow_size[i + 1];
         shadow_free[i] = shadow_free[i + 1];
      end
      shadow_count--;
   endfunction

   function automatic void seg_insert(int unsigned idx, logic [31:0] sz, bit fr);
      for (int unsigned i = shadow_count; i > idx; i--) begin
         shadow_size[i] = shadow_size[i - 1];
         shadow_free[i] = shadow_free[i - 1];
      end
      shadow_size[idx] = sz;
      shadow_free[idx] = fr;
      shadow_count++;
   endfunction

   function automatic alloc_result_type heap_step(fbfha_pkg::req_kind_type kind,
                                                  logic [FW-1:0] sz, logic [FW-1:0] fa);
      alloc_result_type r;
      longint           lim;
      longint           best;
      longint           off;
      longint           addr;
      longint           largest;
      longint           total;
      int unsigned      pos;
      bit               found;
      logic [31:0]      s;
      logic [31:0]      sz32;
      logic [31:0]      hdr32;
      addr = 0;
      found = 0;
      pos = 0;
      sz32 = 32'(sz);
      hdr32 = 32'(cur_hdr);
      r.status = fbfha_pkg::STATUS_NOP;
      if (kind == fbfha_pkg::REQ_ALLOC) begin
         lim = (longint'(cur_limit) < longint'(HBYTE)) ? longint'(cur_limit) : longint'(HBYTE);
         best = 64'h7fff_ffff_ffff_ffff;
         if (sz != 0) begin
            for (int unsigned i = 0; i < shadow_count; i++) begin
               if (shadow_free[i] && shadow_size[i] >= sz32) begin
                  if (!cur_fit || shadow_size[i] == sz32) begin
                     pos = i;
                     found = 1;
                     break;
                  end
                  if (longint'(shadow_size[i] - sz32) < best) begin
                     best = longint'(shadow_size[i] - sz32);
                     pos = i;
                     found = 1;
                  end
               end
            end
            if (found) begin
               s = shadow_size[pos];
               if (longint'(s) >= longint'(sz32) + longint'(hdr32)
                   && shadow_count < NSEG) begin
                  seg_insert(pos + 1, s - sz32 - hdr32, 1);
                  shadow_size[pos] = sz32;
               end
               shadow_free[pos] = 0;
               addr = span_to(pos) + longint'(hdr32);
               r.status = fbfha_pkg::STATUS_DONE;
            end else begin
               off = span_to(shadow_count);
               if (shadow_count >= NSEG || off + longint'(hdr32) + longint'(sz32) > lim) begin
                  r.status = fbfha_pkg::STATUS_OOM;
               end else begin
                  seg_insert(shadow_count, sz32, 0);
                  addr = off + longint'(hdr32);
                  r.status = fbfha_pkg::STATUS_DONE;
               end
            end
         end
      end else if (fa != 0) begin
         off = 0;
         for (int unsigned i = 0; i < shadow_count; i++) begin
            if (off + longint'(hdr32) == longint'(fa)) begin
               pos = i;
               found = 1;
               break;
            end
            off += longint'(hdr32) + longint'(shadow_size[i]);
         end
         if (found && !shadow_free[pos]) begin
            shadow_free[pos] = 1;
            if (pos + 1 < shadow_count && shadow_free[pos + 1]) begin
               shadow_size[pos] = shadow_size[pos] + hdr32 + shadow_size[pos + 1];
               seg_remove(pos + 1);
            end
            if (pos > 0 && shadow_free[pos - 1]) begin
               shadow_size[pos - 1] = shadow_size[pos - 1] + hdr32 + shadow_size[pos];
               seg_remove(pos);
            end
            r.status = fbfha_pkg::STATUS_DONE;
         end
      end
      largest = 0;
      total = 0;
      for (int unsigned i = 0; i < shadow_count; i++) begin
         if (shadow_free[i]) begin
            if (longint'(shadow_size[i]) > largest) largest = longint'(shadow_size[i]);
            total += longint'(hdr32) + longint'(shadow_size[i]);
         end
      end
      r.addr = addr[FW-1:0];
      r.largest = largest[FW-1:0];
      r.total = total[FW-1:0];
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_payload_addr !== e.addr) begin
               $error("payload_addr expected %0d actual %0d", e.addr, rsp_payload_addr);
               errors++;
            end
            if (rsp_largest_free !== e.largest) begin
               $error("largest_free expected %0d actual %0d", e.largest, rsp_largest_free);
               errors++;
            end
            if (rsp_total_free !== e.total) begin
               $error("total_free expected %0d actual %0d", e.total, rsp_total_free);
               errors++;
            end
         end
      end
   end

   task automatic send_word(fbfha_pkg::req_kind_type kind, logic [FW-1:0] sz,
                            logic [FW-1:0] fa, bit typed, alloc_result_type typed_res);
      alloc_result_type r;
      start <= 1'b1;
      req_type <= kind;
      req_size <= sz;
      req_free_addr <= fa;
      do @(posedge clock); while (busy);
      r = heap_step(kind, sz, fa);
      if (typed) r = typed_res;
      pending_results.push_back(r);
      if (kind == fbfha_pkg::REQ_ALLOC && r.status == fbfha_pkg::STATUS_DONE)
         live_addrs.push_back(r.addr);
   endtask

   task automatic sender_gap();
      int n;
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) n = 0;
      else if (p < 95) n = $urandom_range(1, 6);
      else n = $urandom_range(20, 150);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(fbfha_pkg::csr_index_type idx, logic [FW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         fbfha_pkg::CSR_FIT_MODE:     cur_fit = data[0];
         fbfha_pkg::CSR_HEADER_BYTES: cur_hdr = data[HW-1:0];
         fbfha_pkg::CSR_HEAP_LIMIT:   cur_limit = data;
         default: ;
      endcase
      repeat ($urandom_range(0, 3)) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      alloc_result_type dummy;
      int               p;
      int               k;
      logic [FW-1:0]    sz;
      logic [FW-1:0]    fa;
      dummy = '{fbfha_pkg::STATUS_DONE, '0, '0, '0};
      for (int n = 0; n < count; n++) begin
         sz = '0;
         fa = '0;
         if ($urandom_range(0, 99) < ((n < count / 2) ? 75 : 40)) begin
            p = $urandom_range(0, 99);
            if (p < 55) sz = FW'($urandom_range(1, 64));
            else if (p < 80) sz = FW'($urandom_range(65, 4000));
            else if (p < 87) sz = '0;
            else if (p < 95) sz = FW'($urandom_range(0, HBYTE));
            else sz = FW'($urandom_range(1, 20000));
            send_word(fbfha_pkg::REQ_ALLOC, sz, FW'($urandom), 0, dummy);
         end else begin
            p = $urandom_range(0, 99);
            if (p < 72 && live_addrs.size() != 0) begin
               k = $urandom_range(0, live_addrs.size() - 1);
               fa = live_addrs[k];
               live_addrs.delete(k);
            end else if (p < 82) begin
               fa = '0;
            end else begin
               fa = FW'($urandom_range(0, HBYTE));
            end
            send_word(fbfha_pkg::REQ_FREE, FW'($urandom), fa, 0, dummy);
         end
         if (n == count / 3) drain();
         else sender_gap();
      end
      drain();
   endtask

   initial begin
      alloc_result_type none;
      logic [FW-1:0]    lims[10];
      logic [HW-1:0]    hdrs[10];
      none = '{fbfha_pkg::STATUS_DONE, '0, '0, '0};
      errors = 0;
      start = 1'b0;
      req_type = 1'b0;
      req_size = '0;
      req_free_addr = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      cur_fit = fbfha_pkg::FIT_RESET;
      cur_hdr = fbfha_pkg::HDR_RESET;
      cur_limit = fbfha_pkg::LIMIT_RESET;
      shadow_count = 0;

      dir_rows[0]  = '{fbfha_pkg::REQ_ALLOC, 21'd0, 21'd0, 1,
                       '{fbfha_pkg::STATUS_NOP, 21'd0, 21'd0, 21'd0}};
      dir_rows[1]  = '{fbfha_pkg::REQ_FREE, 21'd0, 21'd0, 1,
                       '{fbfha_pkg::STATUS_NOP, 21'd0, 21'd0, 21'd0}};
      dir_rows[2]  = '{fbfha_pkg::REQ_ALLOC, 21'd1048576, 21'd0, 1,
                       '{fbfha_pkg::STATUS_OOM, 21'd0, 21'd0, 21'd0}};
      dir_rows[3]  = '{fbfha_pkg::REQ_ALLOC, 21'd100, 21'd0, 1,
                       '{fbfha_pkg::STATUS_DONE, 21'd32, 21'd0, 21'd0}};
      dir_rows[4]  = '{fbfha_pkg::REQ_ALLOC, 21'd200, 21'd0, 1,
                       '{fbfha_pkg::STATUS_DONE, 21'd164, 21'd0, 21'd0}};
      dir_rows[5]  = '{fbfha_pkg::REQ_ALLOC, 21'd50, 21'd0, 1,
                       '{fbfha_pkg::STATUS_DONE, 21'd396, 21'd0, 21'd0}};
      dir_rows[6]  = '{fbfha_pkg::REQ_FREE, 21'd0, 21'd32, 1,
                       '{fbfha_pkg::STATUS_DONE, 21'd0, 21'd100, 21'd132}};
      dir_rows[7]  = '{fbfha_pkg::REQ_FREE, 21'd0, 21'd32, 1,
                       '{fbfha_pkg::STATUS_NOP, 21'd0, 21'd100, 21'd132}};
      dir_rows[8]  = '{fbfha_pkg::REQ_FREE, 21'd0, 21'd33, 1,
                       '{fbfha_pkg::STATUS_NOP, 21'd0, 21'd100, 21'd132}};
      dir_rows[9]  = '{fbfha_pkg::REQ_FREE, 21'd0, 21'd164, 1,
                       '{fbfha_pkg::STATUS_DONE, 21'd0, 21'd332, 21'd364}};
      dir_rows[10] = '{fbfha_pkg::REQ_ALLOC, 21'd10, 21'd0, 0, none};
      dir_rows[11] = '{fbfha_pkg::REQ_FREE, 21'd0, 21'd396, 0, none};
      dir_rows[12] = '{fbfha_pkg::REQ_ALLOC, 21'd1, 21'd0, 0, none};
      dir_rows[13] = '{fbfha_pkg::REQ_FREE, 21'h1fffff, 21'h1fffff, 0, none};
      dir_rows[14] = '{fbfha_pkg::REQ_ALLOC, 21'h1fffff, 21'h1fffff, 0, none};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].kind, dir_rows[i].size, dir_rows[i].faddr,
                   dir_rows[i].typed, dir_rows[i].res);
         sender_gap();
      end
      drain();

      hdrs = '{13'd32, 13'd0, 13'd4096, 13'd16, 13'd8, 13'd1, 13'd32, 13'd4096, 13'd0, 13'd64};
      lims = '{21'd1048576, 21'd1048576, 21'd1048576, 21'd4000, 21'd0, 21'd1048576,
               21'd20000, 21'd0, 21'd600000, 21'd1048576};
      for (int ph = 0; ph < 10; ph++) begin
         csr_write(fbfha_pkg::CSR_FIT_MODE, FW'(ph % 2) | (FW'($urandom) & 21'h1ffffe));
         csr_write(fbfha_pkg::CSR_HEADER_BYTES, {8'($urandom) & 8'h00, hdrs[ph]});
         csr_write(fbfha_pkg::CSR_HEAP_LIMIT,
                   (ph == 6) ? FW'($urandom_range(0, HBYTE)) : lims[ph]);
         csr_write(fbfha_pkg::csr_index_type'(2'd3), FW'($urandom));
         random_phase(188);
      end

      drain();
      repeat (250) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule

FILE: first_best_fit_heap_allocator.f
+incdir+src
src/fbfha_pkg.sv
src/fbfha_ram.sv
src/fbfha_ctrl.sv
src/fbfha_dp.sv
src/first_best_fit_heap_allocator.sv
bench/testbench.sv
